>>> rtl/texture_sampler_bilinear_assert.svh
// ---------------------------------------------------------------------------
// Texture sampler assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TEXTURE_SAMPLER_BILINEAR_ASSERT_SVH
`define TEXTURE_SAMPLER_BILINEAR_ASSERT_SVH

// same-cycle implication
`define TSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tsb_pkg.sv
// ---------------------------------------------------------------------------
// Texture sampler package
// Types, constants and codes shared by the controller, datapath and top.
// ---------------------------------------------------------------------------
package tsb_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int MAX_SIDE    = 256;
	localparam int IDX_W       = $clog2(MAX_SIDE);
	localparam int CFG_W       = 9;
	localparam int CIDX_W      = 3;
	localparam int COORD_W     = 17;
	localparam int FRAC_W      = 16;
	localparam int PX_W        = COORD_W + IDX_W;
	localparam int ADDR_FULL_W = IDX_W + CFG_W + 1;
	localparam int COL_W       = 24;

	localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(65536);

	localparam logic [CIDX_W-1:0] REG_TEX_WIDTH   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_TEX_HEIGHT  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_ROW_PITCH   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_FILTER_MODE = 3'd3;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	typedef struct packed {
		logic               action;
		logic [15:0]        load_address;
		logic [7:0]         load_red;
		logic [7:0]         load_green;
		logic [7:0]         load_blue;
		logic [COORD_W-1:0] coord_u;
		logic [COORD_W-1:0] coord_v;
	} req_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_COORD,
		S_FETCH,
		S_DRAIN,
		S_VERT,
		S_HORIZ
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       wr_en;
		logic       mul_en;
		logic       coord_en;
		logic       rd_en;
		logic [1:0] rd_idx;
		logic       vert_en;
		logic       horiz_en;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

>>> rtl/tsb_ctrl.sv
// ---------------------------------------------------------------------------
// Texture sampler controller
// Sequences texel loads, coordinate setup, four texel reads, blend and result write.
// ---------------------------------------------------------------------------
module tsb_ctrl
	import tsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_action,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = '0;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_action == ACT_SAMPLE) begin
						cmd.accept = 1'b1;
						state_d    = S_MUL;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_COORD;
			end
			S_COORD: begin
				cmd.coord_en = 1'b1;
				state_d      = S_FETCH;
			end
			S_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = cnt_q;
				cnt_d      = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_VERT;
			end
			S_VERT: begin
				cmd.vert_en = 1'b1;
				state_d     = S_HORIZ;
			end
			S_HORIZ: begin
				if (!sts.out_busy) begin
					cmd.horiz_en = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`include "texture_sampler_bilinear_assert.svh"

	`TSB_ASSERT_NEXT(a_sample_starts, req_valid && !req_stall && req_action == ACT_SAMPLE, state_q == S_MUL, "sample accept did not start setup")
	`TSB_ASSERT_NEXT(a_four_reads, state_q == S_FETCH && cnt_q == 2'd3, state_q == S_DRAIN, "fetch run not four reads")
	`TSB_ASSERT_NEXT(a_load_stays_idle, cmd.wr_en, state_q == S_IDLE, "load left idle")
	`TSB_ASSERT_NOW(a_no_overwrite, cmd.horiz_en, !sts.out_busy, "result written over stalled word")

endmodule

>>> rtl/tsb_datapath.sv
// ---------------------------------------------------------------------------
// Texture sampler datapath
// Config registers, texel memory, coordinate math, blend and result register.
// ---------------------------------------------------------------------------
module tsb_datapath
	import tsb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  req_t              req_data,
	output rsp_t              rsp_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  cmd_t              cmd,
	output sts_t              sts
);

	logic [CFG_W-1:0]       tex_width_q, tex_height_q, row_pitch_q;
	logic                   filter_mode_q;

	logic [23:0]            texel_mem [STORE_DEPTH];
	logic [23:0]            rdata_q;
	logic [23:0]            texel_q [4];
	logic                   cap_en_s1;
	logic [1:0]             cap_idx_s1;

	logic [COORD_W-1:0]     u_q, v_q, u_clamp, v_clamp;
	logic [PX_W-1:0]        px_q, py_q;
	logic [PX_W:0]          px_full, py_full;
	logic [IDX_W-1:0]       x0_q, x1_q, y0_q, y1_q;
	logic [FRAC_W-1:0]      dx_q, dy_q;

	logic [CFG_W-1:0]       w_eff, h_eff, w_mul, h_mul;
	logic [IDX_W-1:0]       w_max, h_max;
	logic [CFG_W-1:0]       xi, yi, x0p1, y0p1;
	logic [IDX_W-1:0]       x0_d, y0_d, x1_d, y1_d;

	logic [IDX_W-1:0]       x_sel, y_sel;
	logic [ADDR_FULL_W-1:0] addr_full;
	logic [ADDR_W-1:0]      rd_addr;

	logic [7:0]             ca [3], cb [3], cc [3], cd [3];
	logic signed [8:0]      vd0 [3], vd1 [3];
	logic signed [25:0]     vs0 [3], vs1 [3];
	logic [COL_W-1:0]       col0_q [3], col1_q [3];

	logic signed [COL_W:0]  hd [3];
	logic signed [41:0]     hacc [3];
	logic [15:0]            hout [3];

	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q   <= CFG_W'(1);
			tex_height_q  <= CFG_W'(1);
			row_pitch_q   <= CFG_W'(1);
			filter_mode_q <= MODE_NEAREST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEX_WIDTH:   tex_width_q   <= cfg_data;
				REG_TEX_HEIGHT:  tex_height_q  <= cfg_data;
				REG_ROW_PITCH:   row_pitch_q   <= cfg_data;
				REG_FILTER_MODE: filter_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (tex_width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (tex_width_q > CFG_W'(MAX_SIDE)) begin
			w_eff = CFG_W'(MAX_SIDE);
		end else begin
			w_eff = tex_width_q;
		end
		if (tex_height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (tex_height_q > CFG_W'(MAX_SIDE)) begin
			h_eff = CFG_W'(MAX_SIDE);
		end else begin
			h_eff = tex_height_q;
		end
		w_max = IDX_W'(w_eff - CFG_W'(1));
		h_max = IDX_W'(h_eff - CFG_W'(1));
		w_mul = (filter_mode_q == MODE_BILINEAR) ? {1'b0, w_max} : w_eff;
		h_mul = (filter_mode_q == MODE_BILINEAR) ? {1'b0, h_max} : h_eff;
	end

	assign u_clamp = (req_data.coord_u > ONE_Q16) ? ONE_Q16 : req_data.coord_u;
	assign v_clamp = (req_data.coord_v > ONE_Q16) ? ONE_Q16 : req_data.coord_v;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			u_q <= u_clamp;
			v_q <= v_clamp;
		end
	end

	assign px_full = u_q * w_mul;
	assign py_full = v_q * h_mul;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			px_q <= px_full[PX_W-1:0];
			py_q <= py_full[PX_W-1:0];
		end
	end

	// nearest mode reads the one texel four times
	always_comb begin
		xi   = px_q[PX_W-1:FRAC_W];
		yi   = py_q[PX_W-1:FRAC_W];
		x0_d = (xi > {1'b0, w_max}) ? w_max : xi[IDX_W-1:0];
		y0_d = (yi > {1'b0, h_max}) ? h_max : yi[IDX_W-1:0];
		x0p1 = {1'b0, x0_d} + CFG_W'(1);
		y0p1 = {1'b0, y0_d} + CFG_W'(1);
		x1_d = (filter_mode_q == MODE_NEAREST || x0p1 > {1'b0, w_max}) ?
			x0_d : x0p1[IDX_W-1:0];
		y1_d = (filter_mode_q == MODE_NEAREST || y0p1 > {1'b0, h_max}) ?
			y0_d : y0p1[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.coord_en) begin
			x0_q <= x0_d;
			x1_q <= x1_d;
			y0_q <= y0_d;
			y1_q <= y1_d;
			dx_q <= (filter_mode_q == MODE_BILINEAR) ? px_q[FRAC_W-1:0] : '0;
			dy_q <= (filter_mode_q == MODE_BILINEAR) ? py_q[FRAC_W-1:0] : '0;
		end
	end

	assign x_sel     = cmd.rd_idx[1] ? x1_q : x0_q;
	assign y_sel     = cmd.rd_idx[0] ? y1_q : y0_q;
	assign addr_full = y_sel * row_pitch_q + x_sel;
	assign rd_addr   = addr_full[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			texel_mem[req_data.load_address[ADDR_W-1:0]] <=
				{req_data.load_red, req_data.load_green, req_data.load_blue};
		end else if (cmd.rd_en) begin
			rdata_q <= texel_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_s1 <= 1'b0;
		end else begin
			cap_en_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		cap_idx_s1 <= cmd.rd_idx;
		if (cap_en_s1) begin
			texel_q[cap_idx_s1] <= rdata_q;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			ca[ch]  = texel_q[0][23-8*ch -: 8];
			cb[ch]  = texel_q[1][23-8*ch -: 8];
			cc[ch]  = texel_q[2][23-8*ch -: 8];
			cd[ch]  = texel_q[3][23-8*ch -: 8];
			vd0[ch] = $signed({1'b0, cb[ch]}) - $signed({1'b0, ca[ch]});
			vd1[ch] = $signed({1'b0, cd[ch]}) - $signed({1'b0, cc[ch]});
			vs0[ch] = $signed({2'b0, ca[ch], 16'b0}) + vd0[ch] * $signed({1'b0, dy_q});
			vs1[ch] = $signed({2'b0, cc[ch], 16'b0}) + vd1[ch] * $signed({1'b0, dy_q});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vert_en) begin
			for (int ch = 0; ch < 3; ch++) begin
				col0_q[ch] <= vs0[ch][COL_W-1:0];
				col1_q[ch] <= vs1[ch][COL_W-1:0];
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			hd[ch]   = $signed({1'b0, col1_q[ch]}) - $signed({1'b0, col0_q[ch]});
			hacc[ch] = $signed({2'b0, col0_q[ch], 16'b0}) + hd[ch] * $signed({1'b0, dx_q})
				+ 42'sd8388608;
			hout[ch] = hacc[ch][39:24];
		end
	end

	assign sts.out_busy = rsp_valid_q & rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.horiz_en) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.horiz_en) begin
			rsp_q.red_out   <= hout[0];
			rsp_q.green_out <= hout[1];
			rsp_q.blue_out  <= hout[2];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

>>> rtl/texture_sampler_bilinear.sv
// Samples step MUL, COORD, FETCH, DRAIN, VERT, HORIZ; the next is taken only back in IDLE.
// The four texel reads share the single port of the texel memory, one per cycle.
// Loads are written while the controller stays in IDLE and may follow back to back.
// A result waits in the output register while the next word is accepted.
// Reset (arst_n low) clears control and config; texel memory is not cleared.
// ---------------------------------------------------------------------------
// Texture sampler, bilinear
// Top level: joins the sequencing controller and the sampling datapath.
// ---------------------------------------------------------------------------
module texture_sampler_bilinear
	import tsb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp_data
);

	cmd_t cmd;
	sts_t sts;

	tsb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req_data.action),
		.req_stall  (req_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	tsb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
